// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the ID3 tag extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/id3_pkg.sv
// Shared types, constants and helper functions of the ID3 tag extractor.
`default_nettype none

package id3_pkg;

  // Width of the tag size limit register and of the derived counters.
  localparam int SIZE_BITS = 28;
  localparam int POS_W     = SIZE_BITS + 1;
  localparam int DEC_W     = 31;
  localparam int CMP_W     = (DEC_W > SIZE_BITS) ? DEC_W : SIZE_BITS;
  localparam int CHK_W     = ((POS_W > DEC_W) ? POS_W : DEC_W) + 2;

  localparam logic [SIZE_BITS-1:0] MAX_TAG_RESET = SIZE_BITS'(100000);

  // Result buffer depth; two free entries are needed to take one byte.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Field codes; FIELD_NONE marks a frame that is not wanted.
  localparam logic [2:0] FIELD_TITLE    = 3'd0;
  localparam logic [2:0] FIELD_ARTIST   = 3'd1;
  localparam logic [2:0] FIELD_ALBUM    = 3'd2;
  localparam logic [2:0] FIELD_GENRE    = 3'd3;
  localparam logic [2:0] FIELD_COMPOSER = 3'd4;
  localparam logic [2:0] FIELD_TRACK    = 3'd5;
  localparam logic [2:0] FIELD_DISC     = 3'd6;
  localparam logic [2:0] FIELD_NONE     = 3'd7;

  // Tag magic and the wanted frame identifiers.
  localparam logic [7:0]  MAGIC_I = 8'h49;
  localparam logic [7:0]  MAGIC_D = 8'h44;
  localparam logic [7:0]  MAGIC_3 = 8'h33;
  localparam logic [7:0]  MAX_VERSION = 8'd4;
  localparam logic [31:0] ID_TIT2 = 32'h54495432;
  localparam logic [31:0] ID_TPE1 = 32'h54504531;
  localparam logic [31:0] ID_TALB = 32'h54414C42;
  localparam logic [31:0] ID_TCON = 32'h54434F4E;
  localparam logic [31:0] ID_TCOM = 32'h54434F4D;
  localparam logic [31:0] ID_TRCK = 32'h5452434B;
  localparam logic [31:0] ID_TPOS = 32'h54504F53;

  // Text encodings that are passed through.
  localparam logic [7:0] ENC_LATIN1 = 8'd0;
  localparam logic [7:0] ENC_UTF8   = 8'd3;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field_code;
    logic [7:0] data_byte;
    logic       value_last;
    logic       run_last;
  } res_t;

  // Results written by the parser into the result buffer in one cycle.
  typedef struct packed {
    res_t       e0;
    res_t       e1;
    logic [1:0] cnt;
  } push_t;

  // A decoded size and whether its coding was legal.
  typedef struct packed {
    logic             ok;
    logic [DEC_W-1:0] size;
  } size_dec_t;

  // Decode a four-byte size, syncsafe (7 bits per byte) or plain.
  function automatic size_dec_t decode_size(logic [31:0] w, logic syncsafe);
    size_dec_t r;
    if (syncsafe) begin
      r.ok   = ((w & 32'h80808080) == 32'h0);
      r.size = {3'b000, w[30:24], w[22:16], w[14:8], w[6:0]};
    end else begin
      r.ok   = !w[31];
      r.size = w[30:0];
    end
    return r;
  endfunction

  // Map a frame identifier to its field code.
  function automatic logic [2:0] lookup_field(logic [31:0] id);
    logic [2:0] f;
    case (id)
      ID_TIT2: f = FIELD_TITLE;
      ID_TPE1: f = FIELD_ARTIST;
      ID_TALB: f = FIELD_ALBUM;
      ID_TCON: f = FIELD_GENRE;
      ID_TCOM: f = FIELD_COMPOSER;
      ID_TRCK: f = FIELD_TRACK;
      ID_TPOS: f = FIELD_DISC;
      default: f = FIELD_NONE;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/id3_if.sv
// Channel interfaces of the ID3 tag extractor: byte input, results and configuration.
`default_nettype none

// Input byte channel.
interface id3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// Result channel.
interface id3_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] field_code;
  logic [7:0] data_byte;
  logic       value_last;
  logic       run_last;

  modport source (output valid, output kind, output field_code, output data_byte,
                  output value_last, output run_last, input ready);
  modport sink   (input valid, input kind, input field_code, input data_byte,
                  input value_last, input run_last, output ready);
endinterface

// Configuration write channel for the tag size limit.
interface id3_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [id3_pkg::SIZE_BITS-1:0]  max_tag_size;

  modport source (output valid, output max_tag_size, input ready);
  modport sink   (input valid, input max_tag_size, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/id3_parser.sv
// Byte parser: input register, tag and frame walker, and result formation.
`default_nettype none
`include "assert_macros.svh"

module id3_parser
  import id3_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  id3_in_if.sink                    in_ch,
  input  wire logic [SIZE_BITS-1:0] max_tag_size_i,
  input  wire logic                 room_i,
  output push_t                     push_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FHDR,
    PH_BODY,
    PH_SKIP,
    PH_IGNORE
  } phase_e;

  // Byte offsets inside the tag header and a frame header.
  localparam logic [POS_W-1:0] OFF_0 = POS_W'(0);
  localparam logic [POS_W-1:0] OFF_1 = POS_W'(1);
  localparam logic [POS_W-1:0] OFF_2 = POS_W'(2);
  localparam logic [POS_W-1:0] OFF_3 = POS_W'(3);
  localparam logic [POS_W-1:0] OFF_5 = POS_W'(5);
  localparam logic [POS_W-1:0] OFF_6 = POS_W'(6);
  localparam logic [POS_W-1:0] OFF_7 = POS_W'(7);
  localparam logic [POS_W-1:0] OFF_8 = POS_W'(8);
  localparam logic [POS_W-1:0] OFF_9 = POS_W'(9);
  localparam logic [POS_W-1:0] OFF_10 = POS_W'(10);

  // Input register.
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             eos_q;

  // Parser state.
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] tag_end_q, tag_end_d;
  logic [31:0]      shift_q, shift_d;
  logic             sync_q, sync_d;
  logic [POS_W-1:0] fcount_q, fcount_d;
  logic [POS_W-1:0] fsize_q, fsize_d;
  logic [2:0]       field_q, field_d;
  logic             sel_q, sel_d;

  logic             fire;
  logic [31:0]      shift_new;
  size_dec_t        dec;
  logic             ok;
  logic             active;
  logic             body_last;
  logic             emit_value;
  res_t             r_val;
  res_t             r_stat;
  logic             has_stat;
  push_t            push;

  // The stage moves on when a byte is held and the result buffer has room.
  assign fire        = in_valid_q && room_i;
  assign in_ch.ready = !in_valid_q || fire;

  assign shift_new = {shift_q[23:0], in_byte_q};
  assign dec       = decode_size(shift_new, sync_q);
  assign body_last = ({1'b0, fcount_q} == ({1'b0, fsize_q} + (POS_W + 1)'(9)));

  // Next state and results for the registered byte.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_end_d  = tag_end_q;
    shift_d    = shift_q;
    sync_d     = sync_q;
    fcount_d   = fcount_q;
    fsize_d    = fsize_q;
    field_d    = field_q;
    sel_d      = sel_q;
    ok         = 1'b1;
    emit_value = 1'b0;
    has_stat   = 1'b0;
    r_val      = '0;
    r_stat     = '0;

    case (phase_q)
      PH_HEADER: begin
        if (pos_q == OFF_0) begin
          ok = (in_byte_q == MAGIC_I);
        end else if (pos_q == OFF_1) begin
          ok = (in_byte_q == MAGIC_D);
        end else if (pos_q == OFF_2) begin
          ok = (in_byte_q == MAGIC_3);
        end else if (pos_q == OFF_3) begin
          ok     = (in_byte_q <= MAX_VERSION);
          sync_d = (in_byte_q == MAX_VERSION);
        end else if (pos_q == OFF_5) begin
          ok = (in_byte_q == 8'h00);
        end else if (pos_q >= OFF_6 && pos_q <= OFF_9) begin
          shift_d = shift_new;
        end
        if (!ok) begin
          phase_d = PH_IGNORE;
        end else if (pos_q == OFF_9) begin
          if (!dec.ok || (CMP_W'(dec.size) > CMP_W'(max_tag_size_i))) begin
            phase_d = PH_IGNORE;
          end else begin
            tag_end_d = POS_W'(dec.size) + OFF_10;
            phase_d   = PH_FHDR;
            fcount_d  = '0;
          end
        end
      end
      PH_FHDR: begin
        if (fcount_q == OFF_0 && in_byte_q == 8'h00) begin
          // Padding ends the frame walk.
          phase_d = PH_SKIP;
        end else begin
          if (fcount_q < OFF_8) begin
            shift_d = shift_new;
          end
          if (fcount_q == OFF_3) begin
            field_d = lookup_field(shift_new);
          end
          if (fcount_q == OFF_7 && (!dec.ok || pos_q < OFF_7
              || (CHK_W'(pos_q) - CHK_W'(7) + CHK_W'(10) + CHK_W'(dec.size))
                 > CHK_W'(tag_end_q))) begin
            // Frame size illegal or running past the tag end.
            phase_d = PH_SKIP;
          end else begin
            if (fcount_q == OFF_7) begin
              fsize_d = POS_W'(dec.size);
            end
            if (fcount_q == OFF_9) begin
              if (fsize_q == '0) begin
                fcount_d = '0;
              end else begin
                phase_d  = PH_BODY;
                fcount_d = OFF_10;
              end
            end else begin
              fcount_d = fcount_q + OFF_1;
            end
          end
        end
      end
      PH_BODY: begin
        if (fcount_q == OFF_10) begin
          sel_d = (in_byte_q == ENC_LATIN1 || in_byte_q == ENC_UTF8)
                  && (field_q != FIELD_NONE);
        end else if (sel_q) begin
          emit_value         = 1'b1;
          r_val.kind         = KIND_VALUE;
          r_val.field_code   = field_q;
          r_val.data_byte    = in_byte_q;
          r_val.value_last   = body_last;
        end
        if (body_last) begin
          phase_d  = PH_FHDR;
          fcount_d = '0;
        end else begin
          fcount_d = fcount_q + OFF_1;
        end
      end
      default: begin
      end
    endcase

    // Tag end and end of stream statuses.
    active = (phase_d == PH_FHDR) || (phase_d == PH_BODY) || (phase_d == PH_SKIP);
    if (active && (({1'b0, pos_q} + (POS_W + 1)'(1)) == {1'b0, tag_end_d})) begin
      has_stat    = 1'b1;
      r_stat.kind = KIND_DONE;
      phase_d     = PH_IGNORE;
    end else if (active && eos_q) begin
      has_stat    = 1'b1;
      r_stat.kind = KIND_TRUNC;
    end

    // Position advance, or a fresh start after the last byte of a file.
    if (eos_q) begin
      phase_d   = PH_HEADER;
      pos_d     = '0;
      tag_end_d = '0;
      shift_d   = '0;
      sync_d    = 1'b0;
      fcount_d  = '0;
      fsize_d   = '0;
      field_d   = FIELD_TITLE;
      sel_d     = 1'b0;
    end else if (phase_d != PH_IGNORE && pos_q != '1) begin
      pos_d = pos_q + OFF_1;
    end

    // Order the results: value byte first, then the status.
    r_val.run_last  = !has_stat;
    r_stat.run_last = 1'b1;
    push = '0;
    if (fire) begin
      if (emit_value) begin
        push.e0  = r_val;
        push.e1  = r_stat;
        push.cnt = has_stat ? 2'd2 : 2'd1;
      end else begin
        push.e0  = r_stat;
        push.cnt = has_stat ? 2'd1 : 2'd0;
      end
    end
  end

  assign push_o = push;

  // Input register and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= '0;
      eos_q      <= 1'b0;
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      tag_end_q  <= '0;
      shift_q    <= '0;
      sync_q     <= 1'b0;
      fcount_q   <= '0;
      fsize_q    <= '0;
      field_q    <= FIELD_TITLE;
      sel_q      <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_q <= 1'b1;
        in_byte_q  <= in_ch.in_byte;
        eos_q      <= in_ch.end_of_stream;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        tag_end_q <= tag_end_d;
        shift_q   <= shift_d;
        sync_q    <= sync_d;
        fcount_q  <= fcount_d;
        fsize_q   <= fsize_d;
        field_q   <= field_d;
        sel_q     <= sel_d;
      end
    end
  end

  // The last byte of a file always leaves a clean parser behind.
  `ASSERT_RST(a_eos_clears, clk_i, rst_ni, (fire && eos_q) |=> (phase_q == PH_HEADER && pos_q == '0))
  // A second result in one cycle can only be a status.
  `ASSERT_RST(a_second_is_status, clk_i, rst_ni, (push.cnt == 2'd2) |-> (push.e1.kind != KIND_VALUE))
  // Nothing comes out of a tag that is being ignored.
  `ASSERT_RST(a_ignore_silent, clk_i, rst_ni, (fire && phase_q == PH_IGNORE) |-> (push.cnt == 2'd0))

endmodule

`default_nettype wire

// File: hw/rtl/id3_res_fifo.sv
// Result buffer: takes up to two results a cycle and hands out one per transfer.
`default_nettype none
`include "assert_macros.svh"

module id3_res_fifo
  import id3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  id3_out_if.source out_ch
);

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_nx;
  res_t               head;

  // Room for two more results means a new byte can be taken.
  assign room_o = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));

  assign head              = mem_q[rd_ptr_q];
  assign out_ch.valid      = (cnt_q != '0);
  assign out_ch.kind       = head.kind;
  assign out_ch.field_code = head.field_code;
  assign out_ch.data_byte  = head.data_byte;
  assign out_ch.value_last = head.value_last;
  assign out_ch.run_last   = head.run_last;

  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_nx = wr_ptr_q + FIFO_AW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FIFO_CW'(push_i.cnt) - FIFO_CW'(pop);
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.e1;
    end
  end

  // Buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_overflow, clk_i, rst_ni, cnt_q > FIFO_CW'(FIFO_DEPTH))
  `ASSERT_RST(a_ptr_count, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_AW-1:0])
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, (push_i.cnt != 2'd0) && !room_o)

endmodule

`default_nettype wire

// File: hw/rtl/id3v2_text_frame_extractor_core.sv
// Top level of the ID3v2 text frame extractor.
`default_nettype none

// The block takes one file byte per transfer and, for an ID3v2 tag whose
// header checks out and whose size is within max_tag_size, emits the text
// bytes of the title, artist, album, genre, composer, track and disc frames
// (encodings 0 and 3), each tagged with its field code, followed by a tag
// complete status at the last tag byte or a truncation status if the file
// ends first; values of a truncated tag must be discarded. One byte is
// taken every cycle while the result buffer has room: a byte is held in
// the input register while the frame walker updates its state, and its
// results go into a four-entry result buffer, from which they are handed
// out. A byte that causes two results (a value byte at the tag or file
// end) is absorbed by the buffer. Write max_tag_size only while no byte
// is in flight.
module id3v2_text_frame_extractor_core
  import id3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  id3_in_if.sink    in_ch,
  id3_out_if.source out_ch,
  id3_cfg_if.sink   cfg_ch
);

  logic [SIZE_BITS-1:0] max_tag_size_q;
  logic                 room;
  push_t                push;

  // Tag size limit register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tag_size_q <= MAX_TAG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_tag_size_q <= cfg_ch.max_tag_size;
    end
  end

  id3_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .max_tag_size_i (max_tag_size_q),
    .room_i         (room),
    .push_o         (push)
  );

  id3_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench of the ID3v2 text frame extractor driven by random byte streams.
`timescale 1ns / 100ps

module tb_top;
  import id3_pkg::*;

  localparam int WATCHDOG_LIMIT      = 4000;
  localparam int DRAIN_CYCLES        = 12;
  localparam int BYTES_PER_PHASE     = 250;
  localparam int NUM_PHASES          = 5;
  localparam logic [SIZE_BITS-1:0] LIMIT_TOP = '1;

  // Wanted frame identifiers, indexed by field code.
  localparam logic [31:0] WANTED_IDS [7] = '{ID_TIT2, ID_TPE1, ID_TALB, ID_TCON,
                                             ID_TCOM, ID_TRCK, ID_TPOS};

  typedef enum logic [2:0] {
    WALK_HEADER, WALK_FRAME_HDR, WALK_BODY, WALK_SKIP, WALK_IGNORE
  } walk_phase_e;

  // Tracks the tag walk byte by byte and holds the results still to come.
  class tag_scoreboard;
    walk_phase_e          phase;
    logic [POS_W-1:0]     file_pos;
    logic [POS_W-1:0]     tag_end;
    logic [31:0]          id_shift;
    bit                   syncsafe;
    logic [POS_W-1:0]     frame_off;
    logic [POS_W-1:0]     frame_len;
    logic [2:0]           field;
    bit                   selected;
    logic [SIZE_BITS-1:0] limit;
    res_t                 pending_results[$];
    int unsigned          failures;

    function new();
      limit    = MAX_TAG_RESET;
      failures = 0;
      restart();
    endfunction

    // State after the end of a file.
    function void restart();
      phase     = WALK_HEADER;
      file_pos  = '0;
      tag_end   = '0;
      id_shift  = '0;
      syncsafe  = 1'b0;
      frame_off = '0;
      frame_len = '0;
      field     = '0;
      selected  = 1'b0;
    endfunction

    // Size in the coding of this tag; returns 0 when the coding is illegal.
    function bit read_size(logic [31:0] w, output logic [30:0] len);
      len = '0;
      if (syncsafe) begin
        for (int i = 3; i >= 0; i--) begin
          if (w[8*i+7]) return 1'b0;
          len = (len << 7) | 31'(w[8*i +: 7]);
        end
        return 1'b1;
      end
      len = w[30:0];
      return !w[31];
    endfunction

    function logic [2:0] field_of(logic [31:0] id);
      for (int i = 0; i < 7; i++) begin
        if (WANTED_IDS[i] == id) return 3'(i);
      end
      return FIELD_NONE;
    endfunction

    // Advance the walk by one accepted byte and queue the results it causes.
    function void note_input(logic [7:0] b, logic eos);
      logic [POS_W-1:0] here;
      logic [30:0]      len;
      bit               ok;
      bit               is_last;
      bit               active;
      res_t             made[$];
      here = file_pos;
      case (phase)
        WALK_HEADER: begin
          ok = 1'b1;
          case (here)
            0: ok = (b == MAGIC_I);
            1: ok = (b == MAGIC_D);
            2: ok = (b == MAGIC_3);
            3: begin
              ok       = (b <= MAX_VERSION);
              syncsafe = (b == MAX_VERSION);
            end
            5: ok = (b == 8'h00);
            6, 7, 8, 9: id_shift = {id_shift[23:0], b};
            default: ;
          endcase
          if (!ok) begin
            phase = WALK_IGNORE;
          end else if (here == 9) begin
            if (!read_size(id_shift, len) || len > limit) begin
              phase = WALK_IGNORE;
            end else begin
              tag_end   = POS_W'(len) + POS_W'(10);
              phase     = WALK_FRAME_HDR;
              frame_off = '0;
            end
          end
        end
        WALK_FRAME_HDR: begin
          // A zero byte where an id should start is padding.
          if (frame_off == 0 && b == 8'h00) begin
            phase = WALK_SKIP;
          end else begin
            if (frame_off < 8) id_shift = {id_shift[23:0], b};
            if (frame_off == 3) field = field_of(id_shift);
            if (frame_off == 7) begin
              if (!read_size(id_shift, len) || here < 7 ||
                  64'(here) - 64'd7 + 64'd10 + 64'(len) > 64'(tag_end)) begin
                phase = WALK_SKIP;
              end else begin
                frame_len = POS_W'(len);
              end
            end
            if (phase == WALK_FRAME_HDR) begin
              if (frame_off == 9) begin
                if (frame_len == 0) begin
                  frame_off = '0;
                end else begin
                  phase     = WALK_BODY;
                  frame_off = POS_W'(10);
                end
              end else begin
                frame_off = frame_off + 1'b1;
              end
            end
          end
        end
        WALK_BODY: begin
          is_last = (frame_off == POS_W'(9) + frame_len);
          if (frame_off == 10) begin
            selected = (b == ENC_LATIN1 || b == ENC_UTF8) && field != FIELD_NONE;
          end else if (selected) begin
            made.push_back('{kind: KIND_VALUE, field_code: field, data_byte: b,
                             value_last: is_last, run_last: 1'b0});
          end
          if (is_last) begin
            phase     = WALK_FRAME_HDR;
            frame_off = '0;
          end else begin
            frame_off = frame_off + 1'b1;
          end
        end
        default: ;
      endcase

      // Status at the last tag byte, or at a file end inside the tag.
      active = (phase == WALK_FRAME_HDR || phase == WALK_BODY || phase == WALK_SKIP);
      if (active && here + 1'b1 == tag_end) begin
        made.push_back('{kind: KIND_DONE, field_code: '0, data_byte: '0,
                         value_last: 1'b0, run_last: 1'b0});
        phase = WALK_IGNORE;
      end else if (active && eos) begin
        made.push_back('{kind: KIND_TRUNC, field_code: '0, data_byte: '0,
                         value_last: 1'b0, run_last: 1'b0});
      end

      if (eos) begin
        restart();
      end else if (phase != WALK_IGNORE && here != '1) begin
        file_pos = here + 1'b1;
      end

      if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
      foreach (made[i]) pending_results.push_back(made[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result with the oldest one still owed.
    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing owed, expected none, got %p", $time, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("field_code", 8'(want.field_code), 8'(got.field_code));
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("value_last", 8'(want.value_last), 8'(got.value_last));
      compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int   quiet_cycles = 0;
  logic [7:0] file_bytes[$];
  tag_scoreboard board = new();

  id3_in_if  in_ch ();
  id3_out_if out_ch ();
  id3_cfg_if cfg_ch ();

  id3v2_text_frame_extractor_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note every transfer on the byte and result channels.
  always @(posedge clk) begin : transfer_monitor
    res_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      board.note_input(in_ch.in_byte, in_ch.end_of_stream);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = out_ch.kind;
      got.field_code = out_ch.field_code;
      got.data_byte  = out_ch.data_byte;
      got.value_last = out_ch.value_last;
      got.run_last   = out_ch.run_last;
      board.check_result(got);
    end
  end

  // End the run when no channel has moved anything for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  initial begin : result_stalls
    int stall = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic void push_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] encode_size(logic [31:0] v, bit ss);
    if (ss) return {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
    return v;
  endfunction

  // Build one file around an ID3v2 tag, now and then with a flaw; returns its length.
  function automatic int build_tag_file();
    logic [7:0]  ver;
    logic [31:0] size_word;
    bit          ss;
    int unsigned len;
    int unsigned declared;
    int          flaw;
    int          cut;
    file_bytes.delete();
    repeat (10) file_bytes.push_back(8'h00);
    ver  = ($urandom_range(0, 4) < 2) ? MAX_VERSION : 8'($urandom_range(0, 3));
    flaw = $urandom_range(0, 19);
    if (flaw == 1) ver = 8'($urandom_range(5, 255));
    ss = (ver == MAX_VERSION);

    // Frames: mostly wanted text frames, sometimes any other id.
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) != 0) begin
        push_word(WANTED_IDS[$urandom_range(0, 6)]);
      end else begin
        push_word({8'($urandom_range(1, 255)), 24'($urandom)});
      end
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 1;
        default: len = $urandom_range(2, 7);
      endcase
      size_word = encode_size(len, ss);
      if (ss && $urandom_range(0, 24) == 0) size_word[8*$urandom_range(0, 3)+7] = 1'b1;
      push_word(size_word);
      file_bytes.push_back(8'($urandom));
      file_bytes.push_back(8'($urandom));
      if (len > 0) begin
        if ($urandom_range(0, 3) != 0) begin
          file_bytes.push_back($urandom_range(0, 1) ? ENC_UTF8 : ENC_LATIN1);
        end else begin
          file_bytes.push_back(8'($urandom));
        end
      end
      if (len > 1) repeat (len - 1) file_bytes.push_back(8'($urandom));
    end

    // Padding after the frames.
    if ($urandom_range(0, 3) == 0) begin
      file_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
    end

    declared = file_bytes.size() - 10;
    if (flaw == 4) declared = (declared > 8) ? declared - $urandom_range(1, 8) : 0;
    if (flaw == 5) declared += $urandom_range(1, 10);
    if (flaw == 6) declared += $urandom_range(100, 200000);
    size_word = encode_size(declared, ss);
    if (flaw == 3) size_word[ss ? 8*$urandom_range(0, 3)+7 : 31] = 1'b1;

    file_bytes[0] = MAGIC_I;
    file_bytes[1] = MAGIC_D;
    file_bytes[2] = MAGIC_3;
    file_bytes[3] = ver;
    file_bytes[4] = 8'($urandom);
    file_bytes[5] = (flaw == 2) ? 8'($urandom_range(1, 255)) : 8'h00;
    for (int i = 0; i < 4; i++) file_bytes[6+i] = size_word[31-8*i -: 8];
    if (flaw == 0) file_bytes[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));

    // Audio bytes after the tag, and now and then a file cut short.
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      file_bytes = file_bytes[0:cut-1];
    end
    return file_bytes.size();
  endfunction

  // One byte transfer, with an idle burst before it now and then.
  task automatic send_byte(logic [7:0] b, logic eos);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.in_byte       = b;
    in_ch.end_of_stream = eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Let every owed result arrive and the pipeline empty.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [SIZE_BITS-1:0] v);
    cfg_ch.valid        = 1'b1;
    cfg_ch.max_tag_size = v;
    do @(posedge clk); while (!cfg_ch.ready);
    board.limit = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin : stimulus
    logic [SIZE_BITS-1:0] limits [NUM_PHASES];
    int                   sent;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_stream = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.max_tag_size = '0;
    rst_n               = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed files under the reset limit: a bad first byte, an empty
    // tag, and a title frame whose one value byte is the last tag byte.
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, MAX_VERSION, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_file();
    file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'h03, 8'hFF, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h0C,
                   ID_TIT2[31:24], ID_TIT2[23:16], ID_TIT2[15:8], ID_TIT2[7:0],
                   8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, ENC_UTF8, 8'hFF};
    send_file();
    wait_idle();

    // Random files under several limits; the last phase runs without idling.
    limits = '{LIMIT_TOP, '0, SIZE_BITS'($urandom_range(8, 60)),
               SIZE_BITS'($urandom_range(1000, 200000)), LIMIT_TOP};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(limits[p]);
      calm = (p == NUM_PHASES - 1);
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          file_bytes.delete();
          repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
        end else begin
          sent += build_tag_file();
        end
        send_file();
      end
      wait_idle();
    end

    if (board.pending_results.size() != 0) begin
      $display("%0t: results owed at the end, expected 0, got %0d", $time,
               board.pending_results.size());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
